### src/rfpg_pkg.sv
// Shared constants and types for the rectangle fill page-run generator.
// Has no dependencies; the geometry decoder and the top level import it.
package rfpg_pkg;

    // Display geometry: columns on each controller chip, 8-row pages per chip.
    localparam int COLS_PER_CHIP = 61;
    localparam int PAGES         = 4;

    // Most runs that one rectangle may produce.
    localparam int RUN_LIMIT = 8;
    localparam int RUN_W     = $clog2(RUN_LIMIT);

    // Page counter covers up to eight pages.
    localparam int PAGE_W = 3;

    // Operation codes of a rectangle command.
    localparam logic [1:0] OP_SET    = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_INVERT = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Decoded rectangle, passed from the geometry decoder to the sequencer.
    typedef struct packed {
        logic              valid;
        logic              left_en;
        logic              right_en;
        logic [PAGE_W-1:0] top_page;
        logic [PAGE_W-1:0] bot_page;
        logic [7:0]        top_mask;
        logic [7:0]        bot_mask;
        logic [5:0]        left_start;
        logic [5:0]        left_count;
        logic [5:0]        right_start;
        logic [5:0]        right_count;
    } t_rect;

endpackage

### src/rfpg_geom.sv
// Geometry decoder: orders and clamps the corners of a registered command
// and derives pages, row masks and per-chip column runs. Uses rfpg_pkg.
module rfpg_geom
    import rfpg_pkg::*;
(
    input  logic [7:0] i_x_first,
    input  logic [7:0] i_y_first,
    input  logic [7:0] i_x_second,
    input  logic [7:0] i_y_second,
    input  logic [1:0] i_req_type,
    output t_rect      o_rect
);

    localparam logic [7:0] COLS     = 8'(COLS_PER_CHIP);
    localparam logic [7:0] LAST_COL = 8'(2 * COLS_PER_CHIP - 1);
    localparam logic [7:0] LAST_ROW = 8'(8 * PAGES - 1);

    logic [7:0] x_lo, x_hi, y_lo, y_hi, x_hi_c, y_hi_c;
    logic [7:0] left_end, right_beg;
    logic [7:0] left_cnt, right_off, right_cnt;

    always_comb begin
        x_lo   = (i_x_first < i_x_second) ? i_x_first  : i_x_second;
        x_hi   = (i_x_first < i_x_second) ? i_x_second : i_x_first;
        y_lo   = (i_y_first < i_y_second) ? i_y_first  : i_y_second;
        y_hi   = (i_y_first < i_y_second) ? i_y_second : i_y_first;
        x_hi_c = (x_hi > LAST_COL) ? LAST_COL : x_hi;
        y_hi_c = (y_hi > LAST_ROW) ? LAST_ROW : y_hi;

        // Left chip ends at the clamped edge or its own last column.
        left_end  = (x_hi_c < COLS) ? x_hi_c : COLS - 8'd1;
        // Right chip starts at the left edge or its own first column.
        right_beg = (x_lo > COLS) ? x_lo : COLS;
        left_cnt  = left_end - x_lo + 8'd1;
        right_off = right_beg - COLS;
        right_cnt = x_hi_c - right_beg + 8'd1;

        o_rect.valid       = (i_req_type != OP_NONE) && (x_lo <= x_hi_c) && (y_lo <= y_hi_c);
        o_rect.left_en     = (x_lo < COLS);
        o_rect.right_en    = (x_hi_c >= COLS);
        o_rect.top_page    = y_lo[5:3];
        o_rect.bot_page    = y_hi_c[5:3];
        o_rect.top_mask    = 8'hFF << y_lo[2:0];
        o_rect.bot_mask    = 8'hFF >> (3'd7 - y_hi_c[2:0]);
        o_rect.left_start  = x_lo[5:0];
        o_rect.left_count  = left_cnt[5:0];
        o_rect.right_start = right_off[5:0];
        o_rect.right_count = right_cnt[5:0];
    end

endmodule

### src/rect_fill_page_run_generator.sv
// Rectangle fill page-run generator, top level: command register, run
// sequencer and result register. Uses rfpg_pkg and rfpg_geom.
// Between taking a command and presenting its first run lie the command
// register and the result register. One run per cycle while the run channel
// does not stall; a command yields from one to eight runs, or none.
// Reset (synchronous, active low) empties the command and result registers.
module rect_fill_page_run_generator
    import rfpg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Command channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_x_first,
    input  logic [7:0] i_y_first,
    input  logic [7:0] i_x_second,
    input  logic [7:0] i_y_second,
    input  logic [1:0] i_req_type,
    // Run channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_chip_sel,
    output logic [1:0] o_page_index,
    output logic [5:0] o_start_column,
    output logic [5:0] o_column_count,
    output logic [7:0] o_bit_mask,
    output logic [1:0] o_op_code,
    output logic       o_last_run
);

    // Command register. It holds the raw transaction; decoding happens from
    // here so that the path into the result register stays short.
    logic [7:0]        r_x_first, r_y_first, r_x_second, r_y_second;
    logic [1:0]        r_req_type;
    logic              r_busy;

    // Sequencer position. On the first step of a command the position is
    // taken from the decoded rectangle rather than from these registers.
    logic              r_first;
    logic              r_chip;
    logic [PAGE_W-1:0] r_page;
    logic [RUN_W-1:0]  r_runs;

    // Result register.
    logic              r_out_valid;
    logic              r_chip_sel;
    logic [1:0]        r_page_index;
    logic [5:0]        r_start_column;
    logic [5:0]        r_column_count;
    logic [7:0]        r_bit_mask;
    logic [1:0]        r_op_code;
    logic              r_last_run;

    t_rect             rect;

    logic              out_free, step, final_step, in_accept;
    logic              first_chip, cur_chip;
    logic [PAGE_W-1:0] cur_page;
    logic              n_chip;
    logic [PAGE_W-1:0] n_page;
    logic [7:0]        cur_mask;

    rfpg_geom u_geom (
        .i_x_first  (r_x_first),
        .i_y_first  (r_y_first),
        .i_x_second (r_x_second),
        .i_y_second (r_y_second),
        .i_req_type (r_req_type),
        .o_rect     (rect)
    );

    always_comb begin
        // The result register can take a new run when empty or being drained.
        out_free   = !r_out_valid || !i_stall;
        step       = r_busy && out_free;

        // Each page visits the left chip first when it is touched.
        first_chip = !rect.left_en;
        cur_chip   = r_first ? first_chip    : r_chip;
        cur_page   = r_first ? rect.top_page : r_page;

        if (!cur_chip && rect.right_en) begin
            n_chip = 1'b1;
            n_page = cur_page;
        end else begin
            n_chip = first_chip;
            n_page = cur_page + PAGE_W'(1);
        end

        // A command with no runs is dropped at its first step. Otherwise the
        // command ends on the right-most run of the bottom page, or when the
        // run limit is reached.
        final_step = !rect.valid
                  || ((cur_page == rect.bot_page) && (cur_chip == rect.right_en))
                  || (r_runs == RUN_W'(RUN_LIMIT - 1));

        cur_mask = 8'hFF;
        if (cur_page == rect.top_page) begin
            cur_mask = cur_mask & rect.top_mask;
        end
        if (cur_page == rect.bot_page) begin
            cur_mask = cur_mask & rect.bot_mask;
        end

        // A new command is taken while the last run of the previous one
        // moves into the result register.
        o_stall   = r_busy && !(step && final_step);
        in_accept = i_valid && !o_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_first     <= 1'b0;
        end else begin
            if (in_accept) begin
                r_x_first  <= i_x_first;
                r_y_first  <= i_y_first;
                r_x_second <= i_x_second;
                r_y_second <= i_y_second;
                r_req_type <= i_req_type;
                r_busy     <= 1'b1;
                r_first    <= 1'b1;
                r_runs     <= '0;
            end else if (step && final_step) begin
                r_busy <= 1'b0;
            end else if (step) begin
                r_first <= 1'b0;
                r_chip  <= n_chip;
                r_page  <= n_page;
                r_runs  <= r_runs + RUN_W'(1);
            end

            if (out_free) begin
                r_out_valid <= step && rect.valid;
            end
            if (step && rect.valid) begin
                r_chip_sel     <= cur_chip;
                r_page_index   <= cur_page[1:0];
                r_start_column <= cur_chip ? rect.right_start : rect.left_start;
                r_column_count <= cur_chip ? rect.right_count : rect.left_count;
                r_bit_mask     <= cur_mask;
                r_op_code      <= r_req_type;
                r_last_run     <= final_step;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_chip_sel     = r_chip_sel;
    assign o_page_index   = r_page_index;
    assign o_start_column = r_start_column;
    assign o_column_count = r_column_count;
    assign o_bit_mask     = r_bit_mask;
    assign o_op_code      = r_op_code;
    assign o_last_run     = r_last_run;

endmodule

### dv/rect_fill_page_run_generator_tb.sv
// Self-checking testbench for rect_fill_page_run_generator: directed and random
// rectangle commands, with every run checked against a predictor built into this file.
// Depends on rfpg_pkg and the RTL of the block alone.
module rect_fill_page_run_generator_tb;
    import rfpg_pkg::*;

    // One column-run descriptor, laid out as the run channel carries it.
    typedef struct packed {
        logic       chip_sel;
        logic [1:0] page_index;
        logic [5:0] start_column;
        logic [5:0] column_count;
        logic [7:0] bit_mask;
        logic [1:0] op_code;
        logic       last_run;
    } t_page_run;

    localparam int LAST_COL = 2 * COLS_PER_CHIP - 1;
    localparam int LAST_ROW = 8 * PAGES - 1;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [7:0] i_x_first    = '0;
    logic [7:0] i_y_first    = '0;
    logic [7:0] i_x_second   = '0;
    logic [7:0] i_y_second   = '0;
    logic [1:0] i_req_type   = OP_SET;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_chip_sel;
    logic [1:0] o_page_index;
    logic [5:0] o_start_column;
    logic [5:0] o_column_count;
    logic [7:0] o_bit_mask;
    logic [1:0] o_op_code;
    logic       o_last_run;

    // Runs still owed by the block, oldest first.
    t_page_run pending_runs[$];
    int        mismatch_count = 0;
    // Idling percentages of the current phase.
    int        send_idle_pct  = 0;
    int        run_stall_pct  = 0;

    rect_fill_page_run_generator i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_x_first      (i_x_first),
        .i_y_first      (i_y_first),
        .i_x_second     (i_x_second),
        .i_y_second     (i_y_second),
        .i_req_type     (i_req_type),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_chip_sel     (o_chip_sel),
        .o_page_index   (o_page_index),
        .o_start_column (o_start_column),
        .o_column_count (o_column_count),
        .o_bit_mask     (o_bit_mask),
        .o_op_code      (o_op_code),
        .o_last_run     (o_last_run)
    );

    always #1 i_clk = ~i_clk;

    // The receiver stalls at random at the rate of the current phase.
    always @(posedge i_clk) begin
        i_stall <= i_rst_n && ($urandom_range(99) < run_stall_pct);
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Works out the runs that one rectangle command produces and queues them.
    // Corners are ordered, the far edges clamped to the screen, and each page
    // from top to bottom yields a left-chip run and then a right-chip run where
    // the rectangle reaches that chip.
    function automatic void predict_runs(input logic [7:0] xa, input logic [7:0] ya,
                                         input logic [7:0] xb, input logic [7:0] yb,
                                         input logic [1:0] op);
        int        x_lo;
        int        x_hi;
        int        y_lo;
        int        y_hi;
        int        top_pg;
        int        bot_pg;
        int        span_end;
        int        span_start;
        logic [7:0] rows;
        t_page_run run;
        t_page_run runs[$];

        if (op == OP_NONE) return;
        x_lo = int'((xa < xb) ? xa : xb);
        x_hi = int'((xa < xb) ? xb : xa);
        y_lo = int'((ya < yb) ? ya : yb);
        y_hi = int'((ya < yb) ? yb : ya);
        if (x_hi > LAST_COL) x_hi = LAST_COL;
        if (y_hi > LAST_ROW) y_hi = LAST_ROW;
        if (x_lo > x_hi || y_lo > y_hi) return;

        top_pg = y_lo / 8;
        bot_pg = y_hi / 8;
        for (int pg = top_pg; pg <= bot_pg; pg++) begin
            rows = 8'hFF;
            if (pg == top_pg) rows = rows << (y_lo % 8);
            if (pg == bot_pg) rows = rows & (8'hFF >> (7 - (y_hi % 8)));
            run.page_index = 2'(pg);
            run.bit_mask   = rows;
            run.op_code    = op;
            run.last_run   = 1'b0;
            if (x_lo < COLS_PER_CHIP) begin
                span_end         = (x_hi < COLS_PER_CHIP) ? x_hi : COLS_PER_CHIP - 1;
                run.chip_sel     = 1'b0;
                run.start_column = 6'(x_lo);
                run.column_count = 6'(span_end - x_lo + 1);
                if (runs.size() < RUN_LIMIT) runs.push_back(run);
            end
            if (x_hi >= COLS_PER_CHIP) begin
                span_start       = (x_lo > COLS_PER_CHIP) ? x_lo : COLS_PER_CHIP;
                run.chip_sel     = 1'b1;
                run.start_column = 6'(span_start - COLS_PER_CHIP);
                run.column_count = 6'(x_hi - span_start + 1);
                if (runs.size() < RUN_LIMIT) runs.push_back(run);
            end
        end
        // Whatever run comes out last closes the rectangle, even if the
        // run limit has cut the list short.
        if (runs.size() > 0) runs[runs.size() - 1].last_run = 1'b1;
        foreach (runs[k]) pending_runs.push_back(runs[k]);
    endfunction

    // Sends one rectangle command and waits until the block takes the
    // transaction; the expected runs are queued at the accepting edge.
    task automatic send_rect(input logic [7:0] xa, input logic [7:0] ya,
                             input logic [7:0] xb, input logic [7:0] yb,
                             input logic [1:0] op);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_x_first  <= xa;
        i_y_first  <= ya;
        i_x_second <= xb;
        i_y_second <= yb;
        i_req_type <= op;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_runs(xa, ya, xb, yb, op);
    endtask

    // Every run the block hands over is held against the oldest expectation.
    always @(posedge i_clk) begin
        t_page_run got;
        t_page_run want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_chip_sel, o_page_index, o_start_column, o_column_count,
                    o_bit_mask, o_op_code, o_last_run};
            if (pending_runs.size() == 0) begin
                report_mismatch($sformatf("unexpected run chip %0d page %0d col %0d",
                                          got.chip_sel, got.page_index, got.start_column));
            end else begin
                want = pending_runs.pop_front();
                if (got !== want) begin
                    report_mismatch($sformatf(
                        "ch %0d/%0d pg %0d/%0d st %0d/%0d n %0d/%0d m %h/%h op %0d/%0d l %0d/%0d",
                        got.chip_sel, want.chip_sel, got.page_index, want.page_index,
                        got.start_column, want.start_column,
                        got.column_count, want.column_count,
                        got.bit_mask, want.bit_mask, got.op_code, want.op_code,
                        got.last_run, want.last_run));
                end
            end
        end
    end

    // Single pixels and the full screen at both extremes of the fields.
    task automatic test_corner_extremes();
        send_rect(8'd0, 8'd0, 8'd0, 8'd0, OP_SET);
        send_rect(8'd255, 8'd255, 8'd0, 8'd0, OP_SET);
        send_rect(8'd0, 8'd0, 8'd255, 8'd255, OP_INVERT);
        send_rect(8'd121, 8'd31, 8'd121, 8'd31, OP_CLEAR);
        send_rect(8'd121, 8'd31, 8'd0, 8'd0, OP_SET);
    endtask

    // Each operation over a rectangle that spans both chips and a page break.
    task automatic test_operations();
        send_rect(8'd10, 8'd3, 8'd100, 8'd12, OP_SET);
        send_rect(8'd100, 8'd12, 8'd10, 8'd3, OP_CLEAR);
        send_rect(8'd10, 8'd12, 8'd100, 8'd3, OP_INVERT);
    endtask

    // Columns either side of the chip boundary and rows either side of a page.
    task automatic test_chip_and_page_boundaries();
        send_rect(8'd60, 8'd7, 8'd60, 8'd8, OP_SET);
        send_rect(8'd61, 8'd7, 8'd61, 8'd8, OP_SET);
        send_rect(8'd60, 8'd0, 8'd61, 8'd7, OP_INVERT);
        send_rect(8'd62, 8'd3, 8'd200, 8'd5, OP_CLEAR);
        send_rect(8'd0, 8'd8, 8'd60, 8'd23, OP_SET);
        send_rect(8'd5, 8'd16, 8'd130, 8'd100, OP_INVERT);
    endtask

    // Commands that produce nothing (the unused operation, a left edge past the
    // last column, a top edge below the last row), then one that does.
    task automatic test_rejected_commands();
        send_rect(8'd0, 8'd0, 8'd121, 8'd31, OP_NONE);
        send_rect(8'd122, 8'd0, 8'd255, 8'd31, OP_SET);
        send_rect(8'd0, 8'd32, 8'd121, 8'd255, OP_CLEAR);
        send_rect(8'd20, 8'd4, 8'd30, 8'd6, OP_SET);
    endtask

    // Random rectangles: mostly on screen, some near the chip boundary, and
    // a share with raw 8-bit fields and any operation code.
    task automatic test_random_mix(input int count, input int gap_pct, input int stall_pct);
        logic [7:0] xa;
        logic [7:0] ya;
        logic [7:0] xb;
        logic [7:0] yb;
        logic [1:0] op;
        int         shape;
        send_idle_pct = gap_pct;
        run_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            shape = $urandom_range(9);
            if (shape < 2) begin
                xa = 8'($urandom_range(255));
                ya = 8'($urandom_range(255));
                xb = 8'($urandom_range(255));
                yb = 8'($urandom_range(255));
                op = 2'($urandom_range(3));
            end else if (shape < 4) begin
                xa = 8'($urandom_range(66, 55));
                xb = 8'($urandom_range(66, 55));
                ya = 8'($urandom_range(LAST_ROW));
                yb = 8'($urandom_range(LAST_ROW));
                op = 2'($urandom_range(2));
            end else begin
                xa = 8'($urandom_range(LAST_COL));
                xb = 8'($urandom_range(LAST_COL));
                ya = 8'($urandom_range(LAST_ROW));
                yb = 8'($urandom_range(LAST_ROW));
                op = 2'($urandom_range(2));
            end
            send_rect(xa, ya, xb, yb, op);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_extremes();
        test_operations();
        test_chip_and_page_boundaries();
        test_rejected_commands();
        test_random_mix(20, 0, 0);
        test_random_mix(20, 53, 0);
        test_random_mix(20, 0, 53);
        test_random_mix(20, 19, 19);

        i_valid <= 1'b0;
        while (pending_runs.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Guards against a hang.
    initial begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
src/rfpg_pkg.sv
src/rfpg_geom.sv
src/rect_fill_page_run_generator.sv
dv/rect_fill_page_run_generator_tb.sv
